/* rtl/mefd_pkg.sv */
// Shared types and constants of the market event frame decoder.
// Used by mefd_front, mefd_back and the top level; depends on nothing else.
package mefd_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] REG_QUOTE_TYPE_CODE  = 2'd1;
    localparam logic [1:0] REG_TRADE_TYPE_CODE  = 2'd2;

    localparam logic [7:0] EXPECTED_VERSION_RESET = 8'd1;
    localparam logic [7:0] QUOTE_TYPE_CODE_RESET  = 8'd1;
    localparam logic [7:0] TRADE_TYPE_CODE_RESET  = 8'd2;

    // Body lengths of the two frame kinds.
    localparam logic [15:0] QUOTE_LEN = 16'd44;
    localparam logic [15:0] TRADE_LEN = 16'd41;

    // Byte offsets of the body fields.
    localparam int SYMBOL_LEN = 12;
    localparam int OFF_SYMBOL = 0;
    localparam int OFF_TS     = 12;
    localparam int OFF_QTY1   = 20;
    localparam int OFF_PX1    = 24;
    localparam int OFF_QTY2   = 32;
    localparam int OFF_PX2    = 36;
    localparam int OFF_AGGR   = 32;
    localparam int OFF_ID     = 33;

    // Number of body bytes a result can ever read.
    localparam int VIEW_BYTES = 44;

    // Width of a body byte index; covers stores of 44 to 64 bytes.
    localparam int BODY_IDX_W = 6;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } mefd_phase_t;

    typedef struct packed {
        logic [7:0] expected_version;
        logic [7:0] quote_type_code;
        logic [7:0] trade_type_code;
    } mefd_cfg_t;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0]            data;
        logic                  wr;
        logic [BODY_IDX_W-1:0] idx;
        logic                  done;
        logic                  err;
        logic                  kind;
    } mefd_op_t;

    typedef struct packed {
        logic               status;
        logic               kind;
        logic [63:0]        symbol_low;
        logic [31:0]        symbol_high;
        logic [63:0]        timestamp;
        logic [31:0]        first_qty;
        logic signed [63:0] first_price;
        logic [31:0]        second_qty;
        logic signed [63:0] second_value;
        logic [7:0]         aggressor_code;
    } mefd_result_t;

endpackage

/* rtl/mefd_fifo.sv */
// Small register queue used between the decoder stages and at the result side.
// Depends on nothing but its parameters.
module mefd_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/mefd_front.sv */
// Front stage: tracks the frame header and body position of each byte and
// classifies frames. Depends on mefd_pkg.
module mefd_front
    import mefd_pkg::*;
#(
    parameter int BODY_STORE_BYTES = 44
) (
    input  logic      clk,
    input  logic      rst_n,
    input  mefd_cfg_t cfg,
    input  logic      byte_valid,
    input  logic [7:0] byte_data,
    output logic      op_valid,
    output mefd_op_t  op
);

    mefd_phase_t phase_reg, phase_next;
    logic [31:0] hdr_reg, hdr_next, hdr_merged;
    logic [15:0] count_reg, count_next;
    logic        halted_reg, halted_next;
    logic [16:0] count_inc;
    logic [15:0] frame_len;
    logic [7:0]  body_type;
    logic        take;
    logic        hdr_last;
    logic        hdr_bad;
    logic        body_last;

    assign take      = byte_valid && !halted_reg;
    assign frame_len = hdr_reg[15:0];
    assign body_type = hdr_reg[23:16];
    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign hdr_last  = (phase_reg == PH_HEADER) && (count_reg[1:0] == 2'd3);
    // A wrong version or an empty body ends the frame with an error at once.
    assign hdr_bad   = (byte_data != cfg.expected_version) || (hdr_merged[15:0] == 16'd0);
    assign body_last = (phase_reg == PH_BODY) && (count_inc >= {1'b0, frame_len});

    always_comb
    begin
        hdr_merged = hdr_reg;
        hdr_merged[8 * count_reg[1:0] +: 8] = byte_data;
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (take && hdr_last && !hdr_bad)
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (take && body_last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // Classification and counters.
    always_comb
    begin
        op          = '0;
        op_valid    = take;
        op.data     = byte_data;
        hdr_next    = hdr_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_next = hdr_merged;
                    if (!hdr_last)
                    begin
                        count_next = 16'(count_reg[1:0]) + 16'd1;
                    end
                    else
                    begin
                        count_next = '0;
                        if (hdr_bad)
                        begin
                            op.done     = 1'b1;
                            op.err      = 1'b1;
                            halted_next = 1'b1;
                            hdr_next    = '0;
                        end
                    end
                end
                PH_BODY:
                begin
                    op.wr  = (count_reg < 16'(BODY_STORE_BYTES));
                    op.idx = count_reg[BODY_IDX_W-1:0];
                    if (body_last)
                    begin
                        op.done    = 1'b1;
                        count_next = '0;
                        hdr_next   = '0;
                        // A quote code wins when both codes are equal.
                        if (body_type == cfg.quote_type_code)
                        begin
                            op.err  = (frame_len != QUOTE_LEN);
                            op.kind = 1'b0;
                        end
                        else if (body_type == cfg.trade_type_code)
                        begin
                            op.err  = (frame_len != TRADE_LEN);
                            op.kind = 1'b1;
                        end
                        else
                        begin
                            op.err = 1'b1;
                        end
                        if (op.err)
                        begin
                            op.kind     = 1'b0;
                            halted_next = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = count_inc[15:0];
                    end
                end
                default:
                begin
                    halted_next = halted_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hdr_reg    <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* rtl/mefd_back.sv */
// Back stage: stores body bytes and builds the result at the last byte of a
// frame. Depends on mefd_pkg.
module mefd_back
    import mefd_pkg::*;
#(
    parameter int BODY_STORE_BYTES = 44
) (
    input  logic         clk,
    input  logic         op_valid,
    input  mefd_op_t     op,
    output logic         op_pop,
    input  logic         res_full,
    output logic         res_push,
    output mefd_result_t res
);

    localparam int IDX_W = $clog2(BODY_STORE_BYTES);

    logic [7:0] body_reg [BODY_STORE_BYTES];
    logic [7:0] view [VIEW_BYTES];

    // A frame end must wait for room in the result queue; other bytes flow.
    assign op_pop   = op_valid && (!op.done || !res_full);
    assign res_push = op_pop && op.done;

    always_ff @(posedge clk)
    begin
        if (op_pop && op.wr)
        begin
            body_reg[op.idx[IDX_W-1:0]] <= op.data;
        end
    end

    // The last body byte is still in flight, so merge it into the view.
    always_comb
    begin
        for (int k = 0; k < VIEW_BYTES; k++)
        begin
            view[k] = (op.wr && (op.idx == BODY_IDX_W'(k))) ? op.data : body_reg[k];
        end
    end

    always_comb
    begin
        res = '0;
        if (op.err)
        begin
            res.status = 1'b1;
        end
        else
        begin
            res.kind = op.kind;
            for (int i = 0; i < 8; i++)
            begin
                res.symbol_low[8*i +: 8]  = view[OFF_SYMBOL + i];
                res.timestamp[8*i +: 8]   = view[OFF_TS + i];
                res.first_price[8*i +: 8] = view[OFF_PX1 + i];
            end
            for (int i = 0; i < SYMBOL_LEN - 8; i++)
            begin
                res.symbol_high[8*i +: 8] = view[OFF_SYMBOL + 8 + i];
            end
            for (int i = 0; i < 4; i++)
            begin
                res.first_qty[8*i +: 8] = view[OFF_QTY1 + i];
            end
            if (op.kind)
            begin
                res.aggressor_code = view[OFF_AGGR];
                for (int i = 0; i < 8; i++)
                begin
                    res.second_value[8*i +: 8] = view[OFF_ID + i];
                end
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res.second_qty[8*i +: 8] = view[OFF_QTY2 + i];
                end
                for (int i = 0; i < 8; i++)
                begin
                    res.second_value[8*i +: 8] = view[OFF_PX2 + i];
                end
            end
        end
    end

endmodule

/* rtl/market_event_frame_decoder.sv */
// Top level of the market event frame decoder: configuration registers, the
// front and back stages and the queues between them. Depends on mefd_pkg,
// mefd_front, mefd_back and mefd_fifo.
//
// Usage. The input side is a queue write port: a stream byte on data_byte is
// taken at a rising edge with push high and full low. Frames carry a 4-byte
// header (16-bit little-endian body length, type byte, version byte) and a
// quote body of 44 bytes or a trade body of 41 bytes. The result side is a
// queue read port: the oldest result shows on the result ports while empty is
// low and is removed at an edge with pop high.
// Throughput is one byte per cycle while full is low, set by the front stage,
// which updates the header and count state once per byte. A result becomes
// visible (empty low) only after the request carrying the last byte of its
// frame is accepted: the accepting edge writes the byte into the two-entry
// stage queue, and a later edge, once the result queue has room, moves it
// through the back stage into the two-entry result queue.
// A framing error (wrong version, empty body, unknown type or wrong length)
// gives one result with status high and every other field zero; the decoder
// then drops every further byte until reset.
// When the receiver stops popping, the result queue fills, the back stage
// holds the frame end, the stage queue fills and full rises; no byte or
// result is lost. Reset empties both queues, clears the frame state and the
// halt, and loads the registers with version 1, quote code 1, trade code 2.
// Configuration writes take effect at once and are meant for an idle block.
module market_event_frame_decoder
    import mefd_pkg::*;
#(
    parameter int BODY_STORE_BYTES = 44
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    output logic               empty,
    input  logic               pop,
    output logic               status,
    output logic               kind,
    output logic [63:0]        symbol_low,
    output logic [31:0]        symbol_high,
    output logic [63:0]        timestamp,
    output logic [31:0]        first_qty,
    output logic signed [63:0] first_price,
    output logic [31:0]        second_qty,
    output logic signed [63:0] second_value,
    output logic [7:0]         aggressor_code
);

    localparam int OP_W  = $bits(mefd_op_t);
    localparam int RES_W = $bits(mefd_result_t);

    mefd_cfg_t    cfg_reg, cfg_next;
    logic         front_valid;
    mefd_op_t     front_op;
    logic         stage_full;
    logic         stage_empty;
    logic [OP_W-1:0] stage_data;
    mefd_op_t     back_op;
    logic         back_pop;
    logic         res_full;
    logic         res_push;
    mefd_result_t back_res;
    logic [RES_W-1:0] res_data;
    mefd_result_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_EXPECTED_VERSION: cfg_next.expected_version = cfg_data;
                REG_QUOTE_TYPE_CODE:  cfg_next.quote_type_code  = cfg_data;
                REG_TRADE_TYPE_CODE:  cfg_next.trade_type_code  = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version <= EXPECTED_VERSION_RESET;
            cfg_reg.quote_type_code  <= QUOTE_TYPE_CODE_RESET;
            cfg_reg.trade_type_code  <= TRADE_TYPE_CODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The stage queue being full is the only thing that stalls the input.
    assign full = stage_full;

    mefd_front #(
        .BODY_STORE_BYTES(BODY_STORE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (push && !stage_full),
        .byte_data  (data_byte),
        .op_valid   (front_valid),
        .op         (front_op)
    );

    mefd_fifo #(
        .DEPTH(2),
        .WIDTH(OP_W)
    ) u_stage_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_valid),
        .wr_data (front_op),
        .full    (stage_full),
        .pop     (back_pop),
        .rd_data (stage_data),
        .empty   (stage_empty)
    );

    assign back_op = mefd_op_t'(stage_data);

    mefd_back #(
        .BODY_STORE_BYTES(BODY_STORE_BYTES)
    ) u_back (
        .clk      (clk),
        .op_valid (!stage_empty),
        .op       (back_op),
        .op_pop   (back_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (back_res)
    );

    mefd_fifo #(
        .DEPTH(2),
        .WIDTH(RES_W)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_data),
        .empty   (empty)
    );

    assign head           = mefd_result_t'(res_data);
    assign status         = head.status;
    assign kind           = head.kind;
    assign symbol_low     = head.symbol_low;
    assign symbol_high    = head.symbol_high;
    assign timestamp      = head.timestamp;
    assign first_qty      = head.first_qty;
    assign first_price    = head.first_price;
    assign second_qty     = head.second_qty;
    assign second_value   = head.second_value;
    assign aggressor_code = head.aggressor_code;

endmodule

/* rtl/mefd_checker.sv */
// Port-level checks of the market event frame decoder and their binding.
// Depends on market_event_frame_decoder.
module mefd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic               status,
    input logic               kind,
    input logic [63:0]        symbol_low,
    input logic [31:0]        symbol_high,
    input logic [63:0]        timestamp,
    input logic [31:0]        first_qty,
    input logic signed [63:0] first_price,
    input logic [31:0]        second_qty,
    input logic signed [63:0] second_value,
    input logic [7:0]         aggressor_code
);

    // An error is the last result before reset: nothing follows it.
    a_halt_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && status) |=> empty)
        else $error("result delivered after a framing error");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> (!kind && symbol_low == 64'd0 && symbol_high == 32'd0
            && timestamp == 64'd0 && first_qty == 32'd0 && first_price == 64'sd0
            && second_qty == 32'd0 && second_value == 64'sd0 && aggressor_code == 8'd0))
        else $error("error result carries nonzero fields");

    a_kind_fillers: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !status) |-> ((kind && second_qty == 32'd0)
            || (!kind && aggressor_code == 8'd0)))
        else $error("field unused by this kind is nonzero");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(kind)
            && $stable(timestamp) && $stable(second_value)))
        else $error("stalled result changed");

endmodule

bind market_event_frame_decoder mefd_checker u_mefd_checker (.*);
